@@ hdl/tpp_pkg.sv @@
package tpp_pkg;

   // Number formats.
   localparam int VALUE_WIDTH  = 32;
   localparam int FRAC_BITS    = 20;
   localparam int LIMIT_WIDTH  = 31;
   localparam int PERIOD_WIDTH = 24;
   localparam int DELTA_WIDTH  = VALUE_WIDTH + 1;
   localparam int DENOM_WIDTH  = LIMIT_WIDTH + 1;
   localparam int MUL_WIDTH    = (DELTA_WIDTH > DENOM_WIDTH) ? DELTA_WIDTH : DENOM_WIDTH;
   localparam int PROD_WIDTH   = 2 * MUL_WIDTH;
   localparam int CALC_WIDTH   = ((VALUE_WIDTH > DENOM_WIDTH) ? VALUE_WIDTH : DENOM_WIDTH) + 2;

   // Snap distance is 1e-4 rad and the brake margin 1e-6, both rounded to the fraction grid.
   localparam longint SNAP_EPS_RAW = ((longint'(1) << FRAC_BITS) + 5000) / 10000;
   localparam longint ACC_EPS_RAW  = ((longint'(1) << FRAC_BITS) + 500000) / 1000000;
   localparam longint ACC_EPS      = (ACC_EPS_RAW > 0) ? ACC_EPS_RAW : 1;
   localparam logic [DELTA_WIDTH-1:0] SNAP_DIST = DELTA_WIDTH'(SNAP_EPS_RAW);
   localparam logic [DENOM_WIDTH-1:0] ACC_PAD   = DENOM_WIDTH'(ACC_EPS);

   // Register map.
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ENABLE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODE        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_SPEED   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_ACCEL   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TICK_PERIOD = 3'd4;

   // Planner modes.
   localparam logic [1:0] MODE_PASS      = 2'd0;
   localparam logic [1:0] MODE_ACCEL     = 2'd1;
   localparam logic [1:0] MODE_TRAPEZOID = 2'd2;

   // Request opcodes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_RESYNC = 1'b1;

   // Multiplier operand selections.
   localparam logic [1:0] MUL_ACC_DT      = 2'd0;
   localparam logic [1:0] MUL_DELTA_DENOM = 2'd1;
   localparam logic [1:0] MUL_VEL_SQ      = 2'd2;
   localparam logic [1:0] MUL_VEL_DT      = 2'd3;

   // Program steps.
   localparam int PC_WIDTH = 4;
   localparam logic [PC_WIDTH-1:0] STEP_DECIDE  = 4'd0;
   localparam logic [PC_WIDTH-1:0] STEP_ACCEL   = 4'd1;
   localparam logic [PC_WIDTH-1:0] STEP_DPROD   = 4'd2;
   localparam logic [PC_WIDTH-1:0] STEP_VPROD   = 4'd3;
   localparam logic [PC_WIDTH-1:0] STEP_BRAKE   = 4'd4;
   localparam logic [PC_WIDTH-1:0] STEP_VNEW    = 4'd5;
   localparam logic [PC_WIDTH-1:0] STEP_MOVE    = 4'd6;
   localparam logic [PC_WIDTH-1:0] STEP_COMMIT  = 4'd7;
   localparam logic [PC_WIDTH-1:0] STEP_SPECIAL = 4'd8;

   typedef struct packed {
      logic                    enable;
      logic [1:0]              mode;
      logic [LIMIT_WIDTH-1:0]  max_speed;
      logic [LIMIT_WIDTH-1:0]  max_accel;
      logic [PERIOD_WIDTH-1:0] tick_period;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          mul_sel;
      logic                ld_delta;
      logic                ld_step;
      logic                ld_dprod;
      logic                ld_vprod;
      logic                ld_brake;
      logic                ld_vnew;
      logic                ld_scaled;
      logic                commit_run;
      logic                commit_special;
      logic                jmp_special;
      logic                fin;
      logic [PC_WIDTH-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic special;
      logic out_free;
   } status_type;

   function automatic ctrl_word_type microcode(input logic [PC_WIDTH-1:0] pc);
      ctrl_word_type cw;
      cw = '0;
      case (pc)
         STEP_DECIDE: begin
            cw.ld_delta    = 1'b1;
            cw.jmp_special = 1'b1;
            cw.target      = STEP_SPECIAL;
         end
         STEP_ACCEL: begin
            cw.mul_sel = MUL_ACC_DT;
            cw.ld_step = 1'b1;
         end
         STEP_DPROD: begin
            cw.mul_sel  = MUL_DELTA_DENOM;
            cw.ld_dprod = 1'b1;
         end
         STEP_VPROD: begin
            cw.mul_sel  = MUL_VEL_SQ;
            cw.ld_vprod = 1'b1;
         end
         STEP_BRAKE: begin
            cw.ld_brake = 1'b1;
         end
         STEP_VNEW: begin
            cw.ld_vnew = 1'b1;
         end
         STEP_MOVE: begin
            cw.mul_sel   = MUL_VEL_DT;
            cw.ld_scaled = 1'b1;
         end
         STEP_COMMIT: begin
            cw.commit_run = 1'b1;
            cw.fin        = 1'b1;
         end
         STEP_SPECIAL: begin
            cw.commit_special = 1'b1;
            cw.fin            = 1'b1;
         end
         default: begin
            cw = '0;
         end
      endcase
      return cw;
   endfunction

endpackage

@@ hdl/tpp_if.sv @@
interface tpp_req_if;
   import tpp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic signed [VALUE_WIDTH-1:0] target_angle;
   logic signed [VALUE_WIDTH-1:0] measured_angle;
   modport source (output valid, op, target_angle, measured_angle, input ready);
   modport sink (input valid, op, target_angle, measured_angle, output ready);
endinterface

interface tpp_rsp_if;
   import tpp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] planned_angle;
   logic signed [VALUE_WIDTH-1:0] planned_speed;
   logic                          drive_valid;
   modport source (output valid, planned_angle, planned_speed, drive_valid, input ready);
   modport sink (input valid, planned_angle, planned_speed, drive_valid, output ready);
endinterface

@@ hdl/trapezoid_position_profile_top.sv @@
// Channel    Direction  Handshake       Payload
// req_chan   in         valid/ready     op, target_angle, measured_angle
// rsp_chan   out        valid/ready     planned_angle, planned_speed, drive_valid
// csr_*      in/out     APB, no waits   enable, mode, max_speed, max_accel, tick_period
//
// A planning tick runs eight steps of the microprogram on the shared multiplier, from the
// decision step to the commit; resync, disabled, pass-through, unused-mode and snap
// requests jump to the special step. Requests are accepted only while the sequencer is idle.
// A finished result waits in the output register; a following request is taken meanwhile
// and holds in its final step until that register is free. Reset clears state and registers.
module trapezoid_position_profile_top (
   input  logic                               clock,
   input  logic                               reset,
   tpp_req_if.sink                            req_chan,
   tpp_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tpp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tpp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import tpp_pkg::*;

   cfg_type       cfg;
   ctrl_word_type ctrl;
   status_type    status;
   logic          busy;
   logic          start;

   assign req_chan.ready = !busy && !reset;
   assign start          = req_chan.valid && req_chan.ready;

   tpp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tpp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   tpp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_op             (req_chan.op),
      .req_target_angle   (req_chan.target_angle),
      .req_measured_angle (req_chan.measured_angle),
      .cfg                (cfg),
      .ctrl               (ctrl),
      .status             (status),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_planned_angle  (rsp_chan.planned_angle),
      .rsp_planned_speed  (rsp_chan.planned_speed),
      .rsp_drive_valid    (rsp_chan.drive_valid)
   );

endmodule

@@ hdl/tpp_csr.sv @@
module tpp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tpp_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [tpp_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [tpp_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output tpp_pkg::cfg_type                     cfg
);
   import tpp_pkg::*;

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic                       wr_en;

   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_ENABLE:      cfg_in.enable      = csr_pwdata[0];
            REG_MODE:        cfg_in.mode        = csr_pwdata[1:0];
            REG_MAX_SPEED:   cfg_in.max_speed   = csr_pwdata[LIMIT_WIDTH-1:0];
            REG_MAX_ACCEL:   cfg_in.max_accel   = csr_pwdata[LIMIT_WIDTH-1:0];
            REG_TICK_PERIOD: cfg_in.tick_period = csr_pwdata[PERIOD_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ENABLE:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.enable);
         REG_MODE:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.mode);
         REG_MAX_SPEED:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.max_speed);
         REG_MAX_ACCEL:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.max_accel);
         REG_TICK_PERIOD: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.tick_period);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/tpp_sequencer.sv @@
module tpp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tpp_pkg::status_type    status,
   output tpp_pkg::ctrl_word_type ctrl,
   output logic                   busy
);
   import tpp_pkg::*;

   logic                busy_ff;
   logic                busy_in;
   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;

   assign ctrl = busy_ff ? microcode(pc_ff) : '0;
   assign busy = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = STEP_DECIDE;
         end
      end else if (ctrl.jmp_special && status.special) begin
         pc_in = ctrl.target;
      end else if (ctrl.fin) begin
         // A final step holds until the result register can take the result.
         if (status.out_free) begin
            busy_in = 1'b0;
         end
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= STEP_DECIDE;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

@@ hdl/tpp_datapath.sv @@
module tpp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 req_op,
   input  logic signed [tpp_pkg::VALUE_WIDTH-1:0] req_target_angle,
   input  logic signed [tpp_pkg::VALUE_WIDTH-1:0] req_measured_angle,
   input  tpp_pkg::cfg_type                     cfg,
   input  tpp_pkg::ctrl_word_type               ctrl,
   output tpp_pkg::status_type                  status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [tpp_pkg::VALUE_WIDTH-1:0] rsp_planned_angle,
   output logic signed [tpp_pkg::VALUE_WIDTH-1:0] rsp_planned_speed,
   output logic                                 rsp_drive_valid
);
   import tpp_pkg::*;

   localparam logic signed [CALC_WIDTH-1:0] VAL_MAX =
      {{(CALC_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
   localparam logic signed [CALC_WIDTH-1:0] VAL_MIN = -VAL_MAX - 1;
   localparam logic [LIMIT_WIDTH-1:0] LIM_MAX = {LIMIT_WIDTH{1'b1}};

   // Request and state.
   logic                          op_ff;
   logic signed [VALUE_WIDTH-1:0] target_ff;
   logic signed [VALUE_WIDTH-1:0] measured_ff;
   logic signed [VALUE_WIDTH-1:0] pos_ff, pos_in;
   logic signed [VALUE_WIDTH-1:0] vel_ff, vel_in;

   // Working registers.
   logic [DELTA_WIDTH-1:0]        abs_delta_ff;
   logic                          dir_neg_ff;
   logic [LIMIT_WIDTH-1:0]        step_ff;
   logic [PROD_WIDTH-1:0]         dprod_ff;
   logic [PROD_WIDTH-1:0]         vprod_ff;
   logic                          brake_ff;
   logic signed [VALUE_WIDTH-1:0] vnew_ff, vnew_in;
   logic [LIMIT_WIDTH-1:0]        scaled_ff;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_angle_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_speed_ff;
   logic                          rsp_drive_ff;

   logic signed [DELTA_WIDTH-1:0] delta;
   logic [DELTA_WIDTH-1:0]        abs_delta;
   logic                          snap;
   logic                          run_mode;
   logic                          out_free;
   logic                          commit;

   logic [DENOM_WIDTH-1:0]        denom;
   logic [VALUE_WIDTH-1:0]        abs_vel;
   logic [VALUE_WIDTH-1:0]        abs_vnew;
   logic [CALC_WIDTH-1:0]         vmag_wide;
   logic [LIMIT_WIDTH-1:0]        vcap;
   logic [MUL_WIDTH-1:0]          mul_a, mul_b;
   logic [PROD_WIDTH-1:0]         product;

   logic signed [CALC_WIDTH-1:0]  vel_wide, step_wide, vsum, spd_pos, spd_neg;
   logic signed [CALC_WIDTH-1:0]  vclamp, vsat;
   logic                          add_step, wrong_way;

   logic signed [CALC_WIDTH-1:0]  pos_wide, tgt_wide, sc_wide, next_pos, next_sat;
   logic                          overshoot;

   assign delta     = DELTA_WIDTH'(target_ff) - DELTA_WIDTH'(pos_ff);
   assign abs_delta = delta[DELTA_WIDTH-1] ? DELTA_WIDTH'(-delta) : DELTA_WIDTH'(delta);
   assign snap      = abs_delta <= SNAP_DIST;
   assign run_mode  = (cfg.mode == MODE_ACCEL) || (cfg.mode == MODE_TRAPEZOID);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.special  = (op_ff == OP_RESYNC) || !cfg.enable || !run_mode || snap;
   assign status.out_free = out_free;

   // Shared multiplier.
   assign denom    = {cfg.max_accel, 1'b0} + ACC_PAD;
   assign abs_vel  = vel_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(-vel_ff) : VALUE_WIDTH'(vel_ff);
   assign abs_vnew = vnew_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(-vnew_ff) : VALUE_WIDTH'(vnew_ff);
   assign vmag_wide = CALC_WIDTH'(abs_vnew);
   assign vcap = (vmag_wide > CALC_WIDTH'(LIM_MAX)) ? LIM_MAX : LIMIT_WIDTH'(abs_vnew);

   always_comb begin
      case (ctrl.mul_sel)
         MUL_ACC_DT: begin
            mul_a = MUL_WIDTH'(cfg.max_accel);
            mul_b = MUL_WIDTH'(cfg.tick_period);
         end
         MUL_DELTA_DENOM: begin
            mul_a = MUL_WIDTH'(abs_delta_ff);
            mul_b = MUL_WIDTH'(denom);
         end
         MUL_VEL_SQ: begin
            mul_a = MUL_WIDTH'(abs_vel);
            mul_b = MUL_WIDTH'(abs_vel);
         end
         MUL_VEL_DT: begin
            mul_a = MUL_WIDTH'(vcap);
            mul_b = MUL_WIDTH'(cfg.tick_period);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

   // Velocity update: the step speeds up toward the target, or slows down when braking.
   assign vel_wide  = CALC_WIDTH'(vel_ff);
   assign step_wide = CALC_WIDTH'(step_ff);
   assign add_step  = (brake_ff == dir_neg_ff);
   assign vsum      = add_step ? vel_wide + step_wide : vel_wide - step_wide;
   assign spd_pos   = CALC_WIDTH'(cfg.max_speed);
   assign spd_neg   = -spd_pos;
   assign vclamp    = (vsum > spd_pos) ? spd_pos : ((vsum < spd_neg) ? spd_neg : vsum);
   assign vsat      = (vclamp > VAL_MAX) ? VAL_MAX : ((vclamp < VAL_MIN) ? VAL_MIN : vclamp);
   assign wrong_way = dir_neg_ff ? (vsat > 0) : (vsat < 0);
   assign vnew_in   = wrong_way ? '0 : vsat[VALUE_WIDTH-1:0];

   // Position update; the displacement carries the sign of the new velocity.
   assign pos_wide  = CALC_WIDTH'(pos_ff);
   assign tgt_wide  = CALC_WIDTH'(target_ff);
   assign sc_wide   = CALC_WIDTH'(scaled_ff);
   assign next_pos  = vnew_ff[VALUE_WIDTH-1] ? pos_wide - sc_wide : pos_wide + sc_wide;
   assign overshoot = dir_neg_ff ? (next_pos <= tgt_wide) : (next_pos >= tgt_wide);
   assign next_sat  = (next_pos > VAL_MAX) ? VAL_MAX :
                      ((next_pos < VAL_MIN) ? VAL_MIN : next_pos);

   assign commit = (ctrl.commit_run || ctrl.commit_special) && out_free;

   always_comb begin
      pos_in = pos_ff;
      vel_in = vel_ff;
      if (ctrl.commit_run) begin
         if (overshoot) begin
            pos_in = target_ff;
            vel_in = '0;
         end else begin
            pos_in = next_sat[VALUE_WIDTH-1:0];
            vel_in = vnew_ff;
         end
      end else if (ctrl.commit_special) begin
         if (op_ff == OP_RESYNC) begin
            pos_in = measured_ff;
            vel_in = '0;
         end else if (cfg.enable) begin
            // Pass-through, an unused mode and a snap all land on the target.
            pos_in = target_ff;
            vel_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff       <= req_op;
         target_ff   <= req_target_angle;
         measured_ff <= req_measured_angle;
      end
      if (ctrl.ld_delta) begin
         abs_delta_ff <= abs_delta;
         dir_neg_ff   <= delta[DELTA_WIDTH-1];
      end
      if (ctrl.ld_step) begin
         step_ff <= product[PERIOD_WIDTH +: LIMIT_WIDTH];
      end
      if (ctrl.ld_dprod) begin
         dprod_ff <= product;
      end
      if (ctrl.ld_vprod) begin
         vprod_ff <= product;
      end
      if (ctrl.ld_brake) begin
         brake_ff <= dprod_ff <= vprod_ff;
      end
      if (ctrl.ld_vnew) begin
         vnew_ff <= vnew_in;
      end
      if (ctrl.ld_scaled) begin
         scaled_ff <= product[PERIOD_WIDTH +: LIMIT_WIDTH];
      end
      if (commit) begin
         rsp_angle_ff <= pos_in;
         rsp_speed_ff <= vel_in;
         rsp_drive_ff <= cfg.enable && (cfg.mode != MODE_PASS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            pos_ff <= pos_in;
            vel_ff <= vel_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_planned_angle = rsp_angle_ff;
   assign rsp_planned_speed = rsp_speed_ff;
   assign rsp_drive_valid   = rsp_drive_ff;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   import tpp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam longint SNAP_LIMIT = ((longint'(1) << FRAC_BITS) + 5000) / 10000;
   localparam longint BRAKE_PAD_RAW = ((longint'(1) << FRAC_BITS) + 500000) / 1000000;
   localparam longint BRAKE_PAD = (BRAKE_PAD_RAW > 0) ? BRAKE_PAD_RAW : 1;
   localparam longint ANGLE_MAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
   localparam longint ANGLE_MIN = -ANGLE_MAX - 1;
   localparam longint RUN_LIMIT = 2000000;

   typedef struct {
      logic                          op;
      logic signed [VALUE_WIDTH-1:0] target;
      logic signed [VALUE_WIDTH-1:0] measured;
   } move_request_type;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] angle;
      logic signed [VALUE_WIDTH-1:0] speed;
      logic                          drive;
   } plan_sample_type;

   logic clock;
   logic reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   tpp_req_if req_bus ();
   tpp_rsp_if rsp_bus ();

   trapezoid_position_profile_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the planner registers and state.
   bit         cfg_enable;
   logic [1:0] cfg_mode;
   longint     cfg_speed;
   longint     cfg_accel;
   longint     cfg_period;
   longint     track_pos;
   longint     track_vel;

   move_request_type pending_moves[$];
   plan_sample_type  expected_plans[$];
   move_request_type offered_move;

   int     sender_idle_pct;
   int     receiver_stall_pct;
   int     hold_cycles_left;
   int     mismatches;
   int     requests_taken;
   int     plans_checked;
   int     settings_applied;
   longint aim;

   task automatic flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic longint clip_angle(longint v);
      if (v > ANGLE_MAX) return ANGLE_MAX;
      if (v < ANGLE_MIN) return ANGLE_MIN;
      return v;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Advances the mirrored planner by one request and returns the sample it reports.
   function automatic plan_sample_type plan_step(move_request_type r);
      plan_sample_type s;
      longint       goal;
      longint       delta;
      longint       dir;
      longint       vel_step;
      longint       move;
      longint       next_pos;
      longint       denom;
      bit [127:0]   dist_prod;
      bit [127:0]   speed_sq;
      if (r.op == OP_RESYNC) begin
         track_pos = longint'(r.measured);
         track_vel = 0;
      end else if (cfg_enable) begin
         goal = longint'(r.target);
         delta = goal - track_pos;
         if (cfg_mode != MODE_ACCEL && cfg_mode != MODE_TRAPEZOID) begin
            track_pos = goal;
            track_vel = 0;
         end else if (magnitude(delta) <= SNAP_LIMIT) begin
            track_pos = goal;
            track_vel = 0;
         end else begin
            dir = (delta > 0) ? 1 : -1;
            vel_step = (cfg_accel * cfg_period) >>> 24;
            denom = 2 * cfg_accel + BRAKE_PAD;
            dist_prod = 128'(magnitude(delta)) * 128'(denom);
            speed_sq = 128'(magnitude(track_vel)) * 128'(magnitude(track_vel));
            // Brake once the remaining distance fits inside v*v/(2a + BRAKE_PAD).
            if (dist_prod <= speed_sq) begin
               track_vel = track_vel - dir * vel_step;
            end else begin
               track_vel = track_vel + dir * vel_step;
            end
            if (track_vel > cfg_speed) track_vel = cfg_speed;
            if (track_vel < -cfg_speed) track_vel = -cfg_speed;
            track_vel = clip_angle(track_vel);
            if ((dir > 0 && track_vel < 0) || (dir < 0 && track_vel > 0)) track_vel = 0;
            move = magnitude(track_vel);
            if (move > ANGLE_MAX) move = ANGLE_MAX;
            move = (move * cfg_period) >>> 24;
            if (track_vel < 0) move = -move;
            next_pos = track_pos + move;
            if ((dir > 0 && next_pos >= goal) || (dir < 0 && next_pos <= goal)) begin
               track_pos = goal;
               track_vel = 0;
            end else begin
               track_pos = clip_angle(next_pos);
            end
         end
      end
      s.angle = track_pos[VALUE_WIDTH-1:0];
      s.speed = track_vel[VALUE_WIDTH-1:0];
      s.drive = cfg_enable && (cfg_mode != MODE_PASS);
      return s;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: a new request is offered only once the previous one has gone.
   always @(posedge clock) begin : drive_requests
      bit offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_plans.push_back(plan_step(offered_move));
            requests_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            offer = (pending_moves.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
            if (offer) begin
               offered_move = pending_moves.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.op             <= offered_move.op;
               req_bus.target_angle   <= offered_move.target;
               req_bus.measured_angle <= offered_move.measured;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_plans
      plan_sample_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            plans_checked++;
            if (expected_plans.size() == 0) begin
               flag_mismatch("response arrived with no request outstanding");
            end else begin
               want = expected_plans.pop_front();
               if (rsp_bus.planned_angle !== want.angle) begin
                  flag_mismatch($sformatf("planned_angle %0d, expected %0d",
                     rsp_bus.planned_angle, want.angle));
               end
               if (rsp_bus.planned_speed !== want.speed) begin
                  flag_mismatch($sformatf("planned_speed %0d, expected %0d",
                     rsp_bus.planned_speed, want.speed));
               end
               if (rsp_bus.drive_valid !== want.drive) begin
                  flag_mismatch($sformatf("drive_valid %b, expected %b",
                     rsp_bus.drive_valid, want.drive));
               end
            end
         end
         rsp_bus.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
   end

   initial begin
      #(RUN_LIMIT * 10);
      $display("timeout: %0d requests taken, %0d responses still outstanding",
         requests_taken, expected_plans.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Writes a register, reads it back and updates the mirror.
   task automatic csr_set(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      if (csr_prdata !== value) begin
         flag_mismatch($sformatf("register %0d reads %h, written %h", index, csr_prdata, value));
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_ENABLE:      cfg_enable = value[0];
         REG_MODE:        cfg_mode   = value[1:0];
         REG_MAX_SPEED:   cfg_speed  = longint'(value[LIMIT_WIDTH-1:0]);
         REG_MAX_ACCEL:   cfg_accel  = longint'(value[LIMIT_WIDTH-1:0]);
         REG_TICK_PERIOD: cfg_period = longint'(value[PERIOD_WIDTH-1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_profile(bit en, logic [1:0] md, longint speed, longint accel,
                                longint period);
      csr_set(REG_ENABLE, CSR_DATA_WIDTH'(en));
      csr_set(REG_MODE, CSR_DATA_WIDTH'(md));
      csr_set(REG_MAX_SPEED, CSR_DATA_WIDTH'(speed));
      csr_set(REG_MAX_ACCEL, CSR_DATA_WIDTH'(accel));
      csr_set(REG_TICK_PERIOD, CSR_DATA_WIDTH'(period));
      settings_applied++;
   endtask

   task automatic random_profile(bit en, logic [1:0] md);
      longint speed;
      longint accel;
      longint period;
      speed  = (longint'($urandom_range(1, 64)) << 20) |
               longint'($urandom_range(0, (1 << 20) - 1));
      accel  = (longint'($urandom_range(1, 400)) << 20) |
               longint'($urandom_range(0, (1 << 20) - 1));
      period = longint'($urandom_range(1 << 16, 1 << 23));
      apply_profile(en, md, speed, accel, period);
   endtask

   task automatic push_tick(longint goal);
      move_request_type r;
      r.op       = OP_TICK;
      r.target   = goal[VALUE_WIDTH-1:0];
      r.measured = $urandom;
      pending_moves.push_back(r);
   endtask

   task automatic push_resync(longint angle);
      move_request_type r;
      r.op       = OP_RESYNC;
      r.target   = $urandom;
      r.measured = angle[VALUE_WIDTH-1:0];
      pending_moves.push_back(r);
   endtask

   // Mostly runs of ticks toward one target, so that the profile accelerates, cruises,
   // brakes and lands; now and then a target flips mid-run or a stray request comes in.
   task automatic queue_moves(int n);
      int            done;
      int            len;
      int            shift;
      longint        off;
      longint        goal;
      move_request_type r;
      done = 0;
      while (done < n) begin
         case ($urandom_range(9))
            0: begin
               r.op       = 1'($urandom_range(1));
               r.target   = $urandom;
               r.measured = $urandom;
               pending_moves.push_back(r);
               if (r.op == OP_RESYNC) aim = longint'(r.measured);
               done++;
            end
            1: begin
               aim = longint'($urandom_range(0, 16 << 20)) - (8 << 20);
               push_resync(aim);
               done++;
            end
            default: begin
               shift = $urandom_range(3, 28);
               off = longint'($urandom_range(0, (1 << shift) - 1));
               if ($urandom_range(1)) off = -off;
               goal = aim + off;
               if (goal > ANGLE_MAX || goal < ANGLE_MIN) goal = aim - off;
               len = $urandom_range(3, 24);
               if (len > n - done) len = n - done;
               for (int i = 0; i < len; i++) begin
                  if (i == len / 2 && $urandom_range(7) == 0) begin
                     goal = 2 * aim - goal;
                     if (goal > ANGLE_MAX || goal < ANGLE_MIN) goal = aim;
                  end
                  push_tick(goal);
               end
               aim = goal;
               done += len;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_moves.size() != 0 || req_bus.valid || expected_plans.size() != 0);
   endtask

   task automatic run_phase(int n, int send_idle, int recv_stall, int hold);
      sender_idle_pct    = send_idle;
      receiver_stall_pct = recv_stall;
      queue_moves(n / 2);
      if (hold > 0) hold_cycles_left = hold;
      wait_drained();
      // The sender sits idle here until every response of the first half is back.
      queue_moves(n - n / 2);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_bus.valid          = 1'b0;
      req_bus.op             = OP_TICK;
      req_bus.target_angle   = '0;
      req_bus.measured_angle = '0;
      rsp_bus.ready          = 1'b0;
      cfg_enable = 1'b0;
      cfg_mode   = MODE_PASS;
      cfg_speed  = 0;
      cfg_accel  = 0;
      cfg_period = 0;
      track_pos  = 0;
      track_vel  = 0;
      aim        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles_left   = 0;
      mismatches       = 0;
      requests_taken   = 0;
      plans_checked    = 0;
      settings_applied = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: ticks are ignored, a resync still loads the angle.
      push_tick(12345);
      push_resync(ANGLE_MAX);
      push_tick(ANGLE_MIN);
      wait_drained();

      apply_profile(1'b1, MODE_PASS, 0, 0, 0);
      push_tick(ANGLE_MIN);
      push_tick(ANGLE_MAX);
      wait_drained();

      apply_profile(1'b1, MODE_UNUSED, 1 << 20, 1 << 20, 1 << 20);
      push_tick(-(3 << 20));
      wait_drained();

      // Largest limits, with a full-range distance to cover.
      apply_profile(1'b1, MODE_ACCEL, ANGLE_MAX, ANGLE_MAX, (1 << PERIOD_WIDTH) - 1);
      push_resync(ANGLE_MIN);
      push_tick(ANGLE_MAX);
      push_tick(ANGLE_MAX);
      push_tick(ANGLE_MIN);
      wait_drained();

      // Snap window edges, then a short profile that accelerates and brakes.
      apply_profile(1'b1, MODE_TRAPEZOID, 2 << 20, 10 << 20, 1 << 20);
      push_resync(0);
      push_tick(SNAP_LIMIT);
      push_resync(0);
      push_tick(-SNAP_LIMIT - 1);
      repeat (5) push_tick(1 << 20);
      wait_drained();

      apply_profile(1'b1, MODE_TRAPEZOID, 2 << 20, 10 << 20, 0);
      push_tick(5 << 20);
      wait_drained();
      apply_profile(1'b1, MODE_ACCEL, 2 << 20, 0, 1 << 20);
      push_tick(-(5 << 20));
      wait_drained();

      random_profile(1'b1, MODE_ACCEL);
      run_phase(60, 0, 0, 0);
      random_profile(1'b1, MODE_TRAPEZOID);
      run_phase(60, 64, 0, 0);
      random_profile(1'b1, MODE_TRAPEZOID);
      run_phase(60, 0, 64, 300);
      random_profile(1'b1, MODE_ACCEL);
      run_phase(60, 24, 24, 0);
      apply_profile(1'b1, MODE_TRAPEZOID, ANGLE_MAX, ANGLE_MAX, (1 << PERIOD_WIDTH) - 1);
      run_phase(40, 24, 24, 0);
      apply_profile(1'b1, MODE_ACCEL, 0, 100 << 20, 1 << 22);
      run_phase(20, 64, 0, 0);
      random_profile(1'b0, MODE_TRAPEZOID);
      run_phase(20, 0, 64, 0);
      random_profile(1'b1, MODE_PASS);
      run_phase(30, 64, 0, 0);
      random_profile(1'b1, MODE_UNUSED);
      run_phase(20, 0, 64, 0);
      random_profile(1'b1, MODE_TRAPEZOID);
      run_phase(50, 0, 0, 0);

      wait_drained();
      repeat (30) @(posedge clock);
      $display("Ran %0d requests under %0d register settings; %0d responses compared.",
         requests_taken, settings_applied, plans_checked);
      $display("Covered every mode, enable off, snapping, braking and extreme limits.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
